>>> design/lwdrc_pkg.sv
// ----------------------------------------------------------------------------
// Line walker package
// Shared constants, request and result types for the line walker with its
// dark-run counter.
// ----------------------------------------------------------------------------
package lwdrc_pkg;

    // Coordinate, count, gray-level and error widths.
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 12;
    localparam int GRAY_BITS  = 8;
    localparam int ERR_BITS   = COORD_BITS + 3;

    // Request type codes.
    localparam logic REQ_START  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Saturation value of the dark-run counter.
    localparam logic [COUNT_BITS-1:0] RUN_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COORD_BITS-1:0]        coord_t;
    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic signed [ERR_BITS-1:0]   err_t;

    // One request as it arrives on the input channel.
    typedef struct packed {
        logic                 req_type;
        logic [11:0]          end_a_x;
        logic [11:0]          end_a_y;
        logic [11:0]          end_b_x;
        logic [11:0]          end_b_y;
        logic [GRAY_BITS-1:0] pixel_gray;
    } lwdrc_req_t;

    // One result as it leaves on the output channel.
    typedef struct packed {
        logic [11:0] point_x;
        logic [11:0] point_y;
        logic [11:0] dark_runs;
        logic        line_done;
    } lwdrc_rsp_t;

    // Contents of the input register handed to the walker.
    typedef struct packed {
        logic       valid;
        lwdrc_req_t req;
    } lwdrc_stage_t;

endpackage

>>> design/line_walk_dark_run_counter_top.sv
// ----------------------------------------------------------------------------
// Line walker with dark-run counter
// Walks a Bresenham line point by point and counts the runs of zero gray
// level met along it.
// ----------------------------------------------------------------------------
// Usage: a start request (req_type 0) carries two endpoints and is answered
// with the first point of the line. Each sample request (req_type 1) carries
// the gray level of the point last given and is answered with the next point,
// or, after the last point, with line_done set, zero coordinates and the final
// dark-run count. A sample with no line in progress answers done with the
// count unchanged; a start during a line drops the old one.
// Both channels use valid/ready. A request taken at one clock edge sits in
// the input register; its result is registered at the next edge where the
// result register is free, and rsp_valid rises from the result register;
// throughput is one request per cycle while rsp_ready holds, set by the
// single-pass walk update between the two registers. When the receiver stalls,
// the result register holds and the input register fills, after which
// req_ready drops until rsp_ready returns.
// Reset empties both registers and clears the walk state; no line is active.
// ----------------------------------------------------------------------------
module line_walk_dark_run_counter_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  lwdrc_pkg::lwdrc_req_t req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output lwdrc_pkg::lwdrc_rsp_t rsp_data
);
    import lwdrc_pkg::*;

    lwdrc_stage_t stage;
    lwdrc_rsp_t   result;
    logic         advance;

    // Input register.
    lwdrc_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .advance   (advance),
        .stage     (stage)
    );

    // Walk state and result logic.
    lwdrc_walker u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .stage   (stage),
        .advance (advance),
        .rsp     (result)
    );

    // Result register.
    lwdrc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_full   (stage.valid),
        .result    (result),
        .advance   (advance),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    // A finished line reports zero coordinates.
    a_done_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.line_done |-> (rsp_data.point_x == '0) && (rsp_data.point_y == '0))
        else $error("done result carries a nonzero point");

    // With both registers full and the receiver stalled, no request is taken.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while both stages are full");

    // A start result always carries a zero count.
    a_start_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (stage.req.req_type == REQ_START)
        |=> rsp_valid && (rsp_data.dark_runs == '0) && !rsp_data.line_done)
        else $error("start result carries a count or done flag");

endmodule

>>> design/lwdrc_in_stage.sv
// ----------------------------------------------------------------------------
// Line walker input register
// Captures one request per cycle while it has room and holds it until the walker consumes it.
// ----------------------------------------------------------------------------
module lwdrc_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  lwdrc_pkg::lwdrc_req_t  req_data,
    input  logic                   advance,
    output lwdrc_pkg::lwdrc_stage_t stage
);
    import lwdrc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    lwdrc_req_t req_reg;

    // The register can take a new request when empty or when its item moves on.
    assign req_ready  = !valid_reg || advance;
    assign valid_next = req_valid || (valid_reg && !advance);

    // Control bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded on every accepted request.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.req   = req_reg;

endmodule

>>> design/lwdrc_walker.sv
// ----------------------------------------------------------------------------
// Line walker core
// Holds the Bresenham walk state and the dark-run counter, and forms the
// result for the request in the input register in a single pass.
// ----------------------------------------------------------------------------
module lwdrc_walker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lwdrc_pkg::lwdrc_stage_t stage,
    input  logic                    advance,
    output lwdrc_pkg::lwdrc_rsp_t   rsp
);
    import lwdrc_pkg::*;

    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t major_end_reg, major_end_next;
    coord_t abs_dx_reg, abs_dx_next;
    coord_t abs_dy_reg, abs_dy_next;
    err_t   err_term_reg, err_term_next;
    logic   major_is_x_reg, major_is_x_next;
    logic   minor_up_reg, minor_up_next;
    logic   last_was_dark_reg, last_was_dark_next;
    count_t run_count_reg, run_count_next;
    logic   line_active_reg, line_active_next;

    // Next state and result for the request being consumed.
    always_comb
    begin
        logic signed [COORD_BITS:0] dx;
        logic signed [COORD_BITS:0] dy;
        logic signed [COORD_BITS:0] mag_x;
        logic signed [COORD_BITS:0] mag_y;
        coord_t adx;
        coord_t ady;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t major;
        err_t   twice_dx;
        err_t   twice_dy;
        logic   dark;
        logic   from_a;

        cur_x_next         = cur_x_reg;
        cur_y_next         = cur_y_reg;
        major_end_next     = major_end_reg;
        abs_dx_next        = abs_dx_reg;
        abs_dy_next        = abs_dy_reg;
        err_term_next      = err_term_reg;
        major_is_x_next    = major_is_x_reg;
        minor_up_next      = minor_up_reg;
        last_was_dark_next = last_was_dark_reg;
        run_count_next     = run_count_reg;
        line_active_next   = line_active_reg;
        rsp                = '0;

        ax = stage.req.end_a_x;
        ay = stage.req.end_a_y;
        bx = stage.req.end_b_x;
        by = stage.req.end_b_y;

        // Endpoint differences and magnitudes.
        dx    = $signed({1'b0, bx}) - $signed({1'b0, ax});
        dy    = $signed({1'b0, by}) - $signed({1'b0, ay});
        mag_x = dx[COORD_BITS] ? -dx : dx;
        mag_y = dy[COORD_BITS] ? -dy : dy;
        adx   = mag_x[COORD_BITS-1:0];
        ady   = mag_y[COORD_BITS-1:0];

        // Doubled step sizes of the stored line.
        twice_dx = $signed({2'b00, abs_dx_reg, 1'b0});
        twice_dy = $signed({2'b00, abs_dy_reg, 1'b0});

        dark  = (stage.req.pixel_gray == '0);
        major = major_is_x_reg ? cur_x_reg : cur_y_reg;
        from_a = 1'b0;

        if (stage.req.req_type == REQ_START)
        begin
            // Set up a new walk from the lower end of the major axis.
            abs_dx_next     = adx;
            abs_dy_next     = ady;
            minor_up_next   = ((dx != '0) && !dx[COORD_BITS] && (dy != '0) && !dy[COORD_BITS])
                              || (dx[COORD_BITS] && dy[COORD_BITS]);
            major_is_x_next = (ady <= adx);
            if (ady <= adx)
            begin
                from_a         = !dx[COORD_BITS];
                major_end_next = from_a ? bx : ax;
                err_term_next  = $signed({2'b00, ady, 1'b0}) - $signed({3'b000, adx});
            end
            else
            begin
                from_a         = !dy[COORD_BITS];
                major_end_next = from_a ? by : ay;
                err_term_next  = $signed({2'b00, adx, 1'b0}) - $signed({3'b000, ady});
            end
            cur_x_next         = from_a ? ax : bx;
            cur_y_next         = from_a ? ay : by;
            last_was_dark_next = 1'b0;
            run_count_next     = '0;
            line_active_next   = 1'b1;
            rsp.point_x        = cur_x_next;
            rsp.point_y        = cur_y_next;
        end
        else if (line_active_reg)
        begin
            // Count the entry into a dark run, then step or finish.
            if (dark && !last_was_dark_reg && (run_count_reg != RUN_MAX))
            begin
                run_count_next = run_count_reg + 1'b1;
            end
            last_was_dark_next = dark;

            if (major >= major_end_reg)
            begin
                line_active_next = 1'b0;
            end
            else if (major_is_x_reg)
            begin
                cur_x_next = cur_x_reg + 1'b1;
                if (err_term_reg[ERR_BITS-1])
                begin
                    err_term_next = err_term_reg + twice_dy;
                end
                else
                begin
                    cur_y_next    = minor_up_reg ? cur_y_reg + 1'b1 : cur_y_reg - 1'b1;
                    err_term_next = err_term_reg + (twice_dy - twice_dx);
                end
            end
            else
            begin
                cur_y_next = cur_y_reg + 1'b1;
                if (err_term_reg[ERR_BITS-1] || (err_term_reg == '0))
                begin
                    err_term_next = err_term_reg + twice_dx;
                end
                else
                begin
                    cur_x_next    = minor_up_reg ? cur_x_reg + 1'b1 : cur_x_reg - 1'b1;
                    err_term_next = err_term_reg + (twice_dx - twice_dy);
                end
            end

            rsp.dark_runs = run_count_next;
            if (line_active_next)
            begin
                rsp.point_x = cur_x_next;
                rsp.point_y = cur_y_next;
            end
            else
            begin
                rsp.line_done = 1'b1;
            end
        end
        else
        begin
            // No line in progress: report done with the count as it stands.
            rsp.dark_runs = run_count_reg;
            rsp.line_done = 1'b1;
        end
    end

    // Walk state, updated when the request moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg         <= '0;
            cur_y_reg         <= '0;
            major_end_reg     <= '0;
            abs_dx_reg        <= '0;
            abs_dy_reg        <= '0;
            err_term_reg      <= '0;
            major_is_x_reg    <= 1'b0;
            minor_up_reg      <= 1'b0;
            last_was_dark_reg <= 1'b0;
            run_count_reg     <= '0;
            line_active_reg   <= 1'b0;
        end
        else if (advance)
        begin
            cur_x_reg         <= cur_x_next;
            cur_y_reg         <= cur_y_next;
            major_end_reg     <= major_end_next;
            abs_dx_reg        <= abs_dx_next;
            abs_dy_reg        <= abs_dy_next;
            err_term_reg      <= err_term_next;
            major_is_x_reg    <= major_is_x_next;
            minor_up_reg      <= minor_up_next;
            last_was_dark_reg <= last_was_dark_next;
            run_count_reg     <= run_count_next;
            line_active_reg   <= line_active_next;
        end
    end

    // A sample with no line in progress leaves the count alone.
    a_idle_sample_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !line_active_reg && (stage.req.req_type == REQ_SAMPLE)
        |=> run_count_reg == $past(run_count_reg))
        else $error("dark-run count changed on a sample with no active line");

    // On a sample the count holds or grows by one; it only clears on a start.
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (stage.req.req_type == REQ_SAMPLE)
        |=> (run_count_reg == $past(run_count_reg))
            || (run_count_reg == $past(run_count_reg) + 1'b1))
        else $error("dark-run count moved by more than one on a sample");

    // State only moves when a request is consumed.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(cur_x_reg) && $stable(cur_y_reg) && $stable(line_active_reg))
        else $error("walk state changed without a request");

endmodule

>>> design/lwdrc_out_stage.sv
// ----------------------------------------------------------------------------
// Line walker result register
// Holds one result until the receiver takes it and decides when the input
// register may hand over its request.
// ----------------------------------------------------------------------------
module lwdrc_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_full,
    input  lwdrc_pkg::lwdrc_rsp_t result,
    output logic                  advance,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output lwdrc_pkg::lwdrc_rsp_t rsp_data
);
    import lwdrc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    lwdrc_rsp_t data_reg;

    // A request moves on when the result register is empty or being emptied.
    assign advance    = in_full && (!valid_reg || rsp_ready);
    assign valid_next = advance || (valid_reg && !rsp_ready);

    // Control bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= result;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule
